// ===== design/spe_pkg.sv =====
`default_nettype none
package spe_pkg;

	localparam int FRAC = 30;
	localparam int COEF_W = 32;
	localparam int PHASE_W = 32;
	localparam int NTERMS = 7;
	localparam logic [30:0] PIH_Q = 31'd1686629713;
	localparam logic [30:0] ONE_Q = 31'h4000_0000;
	localparam logic [15:0] NEG_MASK = 16'hA0C6;

	localparam logic [1:0] ANG_BETA = 2'd0;
	localparam logic [1:0] ANG_SUM  = 2'd1;
	localparam logic [1:0] ANG_DIFF = 2'd2;

	typedef enum logic [3:0] {
		TS_Y,
		TS_Y2,
		TS_Y2M,
		TS_INIT,
		TS_MUL,
		TS_DLD,
		TS_DIV,
		TS_UPD,
		TS_FM,
		TS_FIN,
		TS_K0,
		TS_K1,
		TS_K2,
		TS_K3,
		TS_K4,
		TS_DONE
	} trig_state_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] ar;
		logic signed [COEF_W-1:0] ai;
		logic signed [COEF_W-1:0] br;
		logic signed [COEF_W-1:0] bi;
	} coef_t;

	function automatic logic [7:0] term_div(input logic [2:0] k, input logic cos_sel);
		logic [7:0] d;
		begin
			d = 8'd0;
			if (cos_sel) begin
				case (k)
					3'd0: d = 8'd182;
					3'd1: d = 8'd132;
					3'd2: d = 8'd90;
					3'd3: d = 8'd56;
					3'd4: d = 8'd30;
					3'd5: d = 8'd12;
					3'd6: d = 8'd2;
					default: d = 8'd1;
				endcase
			end else begin
				case (k)
					3'd0: d = 8'd210;
					3'd1: d = 8'd156;
					3'd2: d = 8'd110;
					3'd3: d = 8'd72;
					3'd4: d = 8'd42;
					3'd5: d = 8'd20;
					3'd6: d = 8'd6;
					default: d = 8'd1;
				endcase
			end
			return d;
		end
	endfunction

	// floor(2^32 / d) for the series divisors
	function automatic logic [31:0] term_recip(input logic [2:0] k, input logic cos_sel);
		logic [31:0] m;
		begin
			m = 32'hFFFF_FFFF;
			if (cos_sel) begin
				case (k)
					3'd0: m = 32'd23598721;
					3'd1: m = 32'd32537631;
					3'd2: m = 32'd47721858;
					3'd3: m = 32'd76695844;
					3'd4: m = 32'd143165576;
					3'd5: m = 32'd357913941;
					3'd6: m = 32'd2147483648;
					default: m = 32'hFFFF_FFFF;
				endcase
			end else begin
				case (k)
					3'd0: m = 32'd20452225;
					3'd1: m = 32'd27531841;
					3'd2: m = 32'd39045157;
					3'd3: m = 32'd59652323;
					3'd4: m = 32'd102261126;
					3'd5: m = 32'd214748364;
					3'd6: m = 32'd715827882;
					default: m = 32'hFFFF_FFFF;
				endcase
			end
			return m;
		end
	endfunction

endpackage
`default_nettype wire

// ===== design/spinor_pair_euler_rotation_core.sv =====
// Rotates one spinor pair (up, down) per clock by the SU(2) matrix built from the
// Euler angles alpha, beta, gamma held in three APB registers (offsets 0x0, 0x4,
// 0x8). The sample path is a four-stage pipeline: input register, sixteen
// coefficient-by-sample products, four-term sums, rounding; one pair is taken
// every cycle while out_ready holds. The matrix coefficients come from a
// sequential sine/cosine engine with one shared multiplier that also does the
// series-term divisions by reciprocal multiplication; after reset and after every
// register write it recomputes them, during which in_ready stays low. Write the
// angles only while no pair is in flight.
`default_nettype none
module spinor_pair_euler_rotation_core #(
	parameter int SAMPLE_BITS = 16,
	parameter int ANGLE_BITS  = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [3:0]                    paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] up_re,
	input  wire logic signed [SAMPLE_BITS-1:0] up_im,
	input  wire logic signed [SAMPLE_BITS-1:0] down_re,
	input  wire logic signed [SAMPLE_BITS-1:0] down_im,
	input  wire logic                          last_pair,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS+1:0]      new_up_re,
	output logic signed [SAMPLE_BITS+1:0]      new_up_im,
	output logic signed [SAMPLE_BITS+1:0]      new_down_re,
	output logic signed [SAMPLE_BITS+1:0]      new_down_im,
	output logic                               end_of_matrix
);
	import spe_pkg::*;

	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_GAMMA = 2'd2;

	logic [ANGLE_BITS-1:0] alpha_q, beta_q, gamma_q;
	logic  wr;
	coef_t coef;
	logic  coef_ready;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= '0;
			gamma_q <= '0;
		end else if (wr) begin
			case (paddr[3:2])
				REG_ALPHA: alpha_q <= pwdata[ANGLE_BITS-1:0];
				REG_BETA:  beta_q  <= pwdata[ANGLE_BITS-1:0];
				REG_GAMMA: gamma_q <= pwdata[ANGLE_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ALPHA: prdata = 32'(alpha_q);
			REG_BETA:  prdata = 32'(beta_q);
			REG_GAMMA: prdata = 32'(gamma_q);
			default:   prdata = '0;
		endcase
	end

	spe_trig_engine #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_trig (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (wr),
		.alpha_angle(alpha_q),
		.beta_angle (beta_q),
		.gamma_angle(gamma_q),
		.coef       (coef),
		.coef_ready (coef_ready)
	);

	spe_mac_pipe #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.coef         (coef),
		.coef_ready   (coef_ready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.up_re        (up_re),
		.up_im        (up_im),
		.down_re      (down_re),
		.down_im      (down_im),
		.last_pair    (last_pair),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.new_up_re    (new_up_re),
		.new_up_im    (new_up_im),
		.new_down_re  (new_down_re),
		.new_down_im  (new_down_im),
		.end_of_matrix(end_of_matrix)
	);

endmodule
`default_nettype wire

// ===== design/spe_trig_engine.sv =====
`default_nettype none
module spe_trig_engine #(
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  restart,
	input  wire logic [ANGLE_BITS-1:0] alpha_angle,
	input  wire logic [ANGLE_BITS-1:0] beta_angle,
	input  wire logic [ANGLE_BITS-1:0] gamma_angle,
	output spe_pkg::coef_t             coef,
	output logic                       coef_ready
);
	import spe_pkg::*;

	trig_state_t state_q, state_nx;
	logic [1:0]  ang_q;
	logic [2:0]  k_q;
	logic        cos_q;
	logic [30:0] y_q;
	logic [31:0] y2_q;
	logic [30:0] rs_q, rc_q;
	logic [31:0] num_q;
	logic [31:0] quo_q;
	logic signed [65:0] prod_q;
	logic signed [COEF_W-1:0] sn_q [3];
	logic signed [COEF_W-1:0] cs_q [3];
	logic signed [COEF_W-1:0] ar_q, ai_q, br_q, bi_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	logic               mul_en;
	logic [ANGLE_BITS-1:0] phase;
	logic [PHASE_W-1:0] turn;
	logic [7:0]  dv;
	logic [31:0] rcp;
	logic [31:0] rem;
	logic        qbit;
	logic [31:0] quo;
	logic signed [33:0] diff;
	logic [31:0] s0_raw;
	logic [30:0] s0;
	logic signed [COEF_W-1:0] s0w, c0w;
	logic signed [65:0] rnd_sum;
	logic signed [COEF_W-1:0] rnd;

	always_comb begin
		case (ang_q)
			ANG_BETA: phase = beta_angle;
			ANG_SUM:  phase = alpha_angle + gamma_angle;
			ANG_DIFF: phase = alpha_angle - gamma_angle;
			default:  phase = beta_angle;
		endcase
		turn = {phase, {(PHASE_W-ANGLE_BITS){1'b0}}};
	end

	// quotient estimate by reciprocal is low by at most one
	assign dv    = term_div(k_q, cos_q);
	assign rcp   = term_recip(k_q, cos_q);
	assign rem   = num_q - prod_q[31:0];
	assign qbit  = (rem >= {24'd0, dv});
	assign quo   = quo_q + {31'd0, qbit};
	assign diff  = $signed({3'b000, ONE_Q}) - $signed({2'b00, quo});
	assign s0_raw = prod_q[61:30];
	assign s0    = (s0_raw > {1'b0, ONE_Q}) ? ONE_Q : s0_raw[30:0];
	assign s0w   = $signed({1'b0, s0});
	assign c0w   = $signed({1'b0, rc_q});
	assign rnd_sum = prod_q + 66'sd536870912;
	assign rnd   = rnd_sum[61:30];
	assign prod  = mul_a * mul_b;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			TS_Y:    state_nx = TS_Y2;
			TS_Y2:   state_nx = TS_Y2M;
			TS_Y2M:  state_nx = TS_INIT;
			TS_INIT: state_nx = TS_MUL;
			TS_MUL:  state_nx = TS_DLD;
			TS_DLD:  state_nx = TS_DIV;
			TS_DIV:  state_nx = TS_UPD;
			TS_UPD:  state_nx = (cos_q && k_q == 3'(NTERMS-1)) ? TS_FM : TS_MUL;
			TS_FM:   state_nx = TS_FIN;
			TS_FIN:  state_nx = (ang_q == ANG_DIFF) ? TS_K0 : TS_Y;
			TS_K0:   state_nx = TS_K1;
			TS_K1:   state_nx = TS_K2;
			TS_K2:   state_nx = TS_K3;
			TS_K3:   state_nx = TS_K4;
			TS_K4:   state_nx = TS_DONE;
			TS_DONE: state_nx = TS_DONE;
			default: state_nx = TS_Y;
		endcase
		if (restart)
			state_nx = TS_Y;
	end

	// multiplier operands
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (state_q)
			TS_Y: begin
				mul_a = $signed({3'b000, turn[29:0]});
				mul_b = $signed({2'b00, PIH_Q});
			end
			TS_Y2M: begin
				mul_a = $signed({2'b00, y_q});
				mul_b = $signed({2'b00, y_q});
			end
			TS_MUL: begin
				mul_a = $signed({1'b0, y2_q});
				mul_b = cos_q ? $signed({2'b00, rc_q}) : $signed({2'b00, rs_q});
			end
			TS_DLD: begin
				mul_a = $signed({1'b0, prod_q[61:30]});
				mul_b = $signed({1'b0, rcp});
			end
			TS_DIV: begin
				mul_a = $signed({1'b0, prod_q[63:32]});
				mul_b = $signed({25'd0, dv});
			end
			TS_FM: begin
				mul_a = $signed({2'b00, y_q});
				mul_b = $signed({2'b00, rs_q});
			end
			TS_K0: begin
				mul_a = {cs_q[0][COEF_W-1], cs_q[0]};
				mul_b = {cs_q[1][COEF_W-1], cs_q[1]};
			end
			TS_K1: begin
				mul_a = {cs_q[0][COEF_W-1], cs_q[0]};
				mul_b = {sn_q[1][COEF_W-1], sn_q[1]};
			end
			TS_K2: begin
				mul_a = {sn_q[0][COEF_W-1], sn_q[0]};
				mul_b = {cs_q[2][COEF_W-1], cs_q[2]};
			end
			TS_K3: begin
				mul_a = {sn_q[0][COEF_W-1], sn_q[0]};
				mul_b = {sn_q[2][COEF_W-1], sn_q[2]};
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TS_Y;
			ang_q   <= ANG_BETA;
			k_q     <= '0;
			cos_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (restart) begin
				ang_q <= ANG_BETA;
			end else begin
				case (state_q)
					TS_INIT: begin
						k_q   <= '0;
						cos_q <= 1'b0;
					end
					TS_UPD: begin
						cos_q <= ~cos_q;
						if (cos_q)
							k_q <= k_q + 3'd1;
					end
					TS_FIN: ang_q <= ang_q + 2'd1;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= prod;
		case (state_q)
			TS_Y2: y_q <= prod_q[60:30];
			TS_INIT: begin
				y2_q <= prod_q[61:30];
				rs_q <= ONE_Q;
				rc_q <= ONE_Q;
			end
			TS_DLD: num_q <= prod_q[61:30];
			TS_DIV: quo_q <= prod_q[63:32];
			TS_UPD: begin
				if (cos_q)
					rc_q <= diff[33] ? 31'd0 : diff[30:0];
				else
					rs_q <= diff[30:0];
			end
			TS_FIN: begin
				case (turn[31:30])
					2'd0: begin
						sn_q[ang_q] <= s0w;
						cs_q[ang_q] <= c0w;
					end
					2'd1: begin
						sn_q[ang_q] <= c0w;
						cs_q[ang_q] <= -s0w;
					end
					2'd2: begin
						sn_q[ang_q] <= -s0w;
						cs_q[ang_q] <= -c0w;
					end
					default: begin
						sn_q[ang_q] <= -c0w;
						cs_q[ang_q] <= s0w;
					end
				endcase
			end
			TS_K1: ar_q <= rnd;
			TS_K2: ai_q <= -rnd;
			TS_K3: br_q <= rnd;
			TS_K4: bi_q <= -rnd;
			default: ;
		endcase
	end

	assign coef_ready = (state_q == TS_DONE);
	assign coef = '{ar: ar_q, ai: ai_q, br: br_q, bi: bi_q};

endmodule
`default_nettype wire

// ===== design/spe_mac_pipe.sv =====
`default_nettype none
module spe_mac_pipe #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  spe_pkg::coef_t                     coef,
	input  wire logic                          coef_ready,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0] up_re,
	input  wire logic signed [SAMPLE_BITS-1:0] up_im,
	input  wire logic signed [SAMPLE_BITS-1:0] down_re,
	input  wire logic signed [SAMPLE_BITS-1:0] down_im,
	input  wire logic                          last_pair,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS+1:0]      new_up_re,
	output logic signed [SAMPLE_BITS+1:0]      new_up_im,
	output logic signed [SAMPLE_BITS+1:0]      new_down_re,
	output logic signed [SAMPLE_BITS+1:0]      new_down_im,
	output logic                               end_of_matrix
);
	import spe_pkg::*;

	localparam int PW = COEF_W + SAMPLE_BITS;
	localparam int AW = PW + 2;
	localparam int OW = SAMPLE_BITS + 2;

	logic en;
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic signed [SAMPLE_BITS-1:0] smp_s1 [4];
	logic last_s1, last_s2, last_s3, last_s4;
	logic signed [PW-1:0] pr_s2 [16];
	logic signed [AW-1:0] acc_s3 [4];
	logic signed [AW-1:0] acc_c [4];
	logic signed [OW-1:0] res_s4 [4];
	logic signed [COEF_W-1:0] cf [4];
	logic signed [AW-1:0] rsum [4];

	assign en       = !v4_s4 || out_ready;
	assign in_ready = en && coef_ready;

	assign cf[0] = coef.ar;
	assign cf[1] = coef.ai;
	assign cf[2] = coef.br;
	assign cf[3] = coef.bi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else if (en) begin
			v1_s1 <= in_valid && in_ready;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
		end
	end

	always_comb begin
		for (int o = 0; o < 4; o++) begin
			acc_c[o] = '0;
			for (int j = 0; j < 4; j++) begin
				if (NEG_MASK[o*4+j])
					acc_c[o] = acc_c[o] - AW'(pr_s2[o*4+j]);
				else
					acc_c[o] = acc_c[o] + AW'(pr_s2[o*4+j]);
			end
			rsum[o] = acc_s3[o] + (AW'(1) <<< (FRAC - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			smp_s1[0] <= up_re;
			smp_s1[1] <= up_im;
			smp_s1[2] <= down_re;
			smp_s1[3] <= down_im;
			last_s1   <= last_pair;
			for (int o = 0; o < 4; o++)
				for (int j = 0; j < 4; j++)
					pr_s2[o*4+j] <= PW'(cf[j]) * PW'(smp_s1[o ^ j]);
			last_s2 <= last_s1;
			for (int o = 0; o < 4; o++)
				acc_s3[o] <= acc_c[o];
			last_s3 <= last_s2;
			for (int o = 0; o < 4; o++)
				res_s4[o] <= rsum[o][FRAC+OW-1:FRAC];
			last_s4 <= last_s3;
		end
	end

	assign out_valid     = v4_s4;
	assign new_up_re     = res_s4[0];
	assign new_up_im     = res_s4[1];
	assign new_down_re   = res_s4[2];
	assign new_down_im   = res_s4[3];
	assign end_of_matrix = last_s4;

endmodule
`default_nettype wire

// ===== design/spe_checker.sv =====
`default_nettype none
module spe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);

	// a stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	// a register write restarts the coefficient engine
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite |=> !in_ready)
		else $error("in_ready high right after register write");

	// no input transaction while the output side is blocked
	a_ready_path: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("in_ready high with full stalled pipeline");

endmodule

bind spinor_pair_euler_rotation_core spe_checker u_spe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready)
);
`default_nettype wire

// ===== test/spe_rotation_checker.sv =====
`timescale 1ns / 1ps
module spe_rotation_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               pready,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic signed [15:0] up_re,
	input  wire logic signed [15:0] up_im,
	input  wire logic signed [15:0] down_re,
	input  wire logic signed [15:0] down_im,
	input  wire logic               last_pair,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [17:0] new_up_re,
	input  wire logic signed [17:0] new_up_im,
	input  wire logic signed [17:0] new_down_re,
	input  wire logic signed [17:0] new_down_im,
	input  wire logic               end_of_matrix,
	output int                      fail_count,
	output int                      pending,
	output int                      pairs_checked
);

	localparam longint UNIT_Q30 = 64'sd1 << 30;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_GAMMA = 2'd2;

	typedef struct {
		logic [17:0] up_re;
		logic [17:0] up_im;
		logic [17:0] dn_re;
		logic [17:0] dn_im;
		logic        eom;
	} rotated_pair_t;

	rotated_pair_t rotated_q[$];
	logic [15:0] alpha_q, beta_q, gamma_q;
	int mismatches;

	function automatic longint round_q30(input longint x);
		return (x + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void half_angle_trig(input logic [15:0] idx, output longint sn,
			output longint cs);
		logic [31:0] turn;
		longint f, y, y2, rs, rc, s0, c0;
		begin
			turn = {idx, 16'h0};
			f = longint'(turn[29:0]);
			y = (f * HALF_PI_Q30) >>> 30;
			y2 = (y * y) >>> 30;
			rs = UNIT_Q30;
			rc = UNIT_Q30;
			for (int n = 14; n >= 2; n -= 2) begin
				rs = UNIT_Q30 - ((y2 * rs) >>> 30) / longint'(n * (n + 1));
				rc = UNIT_Q30 - ((y2 * rc) >>> 30) / longint'((n - 1) * n);
				if (rc < 0) rc = 0;
			end
			s0 = (y * rs) >>> 30;
			if (s0 < 0) s0 = 0;
			if (s0 > UNIT_Q30) s0 = UNIT_Q30;
			c0 = rc > UNIT_Q30 ? UNIT_Q30 : rc;
			case (turn[31:30])
				2'd0: begin sn = s0; cs = c0; end
				2'd1: begin sn = c0; cs = -s0; end
				2'd2: begin sn = -s0; cs = -c0; end
				default: begin sn = -c0; cs = s0; end
			endcase
		end
	endfunction

	function automatic rotated_pair_t rotate_pair(input longint ur, ui, dr, di,
			input logic eom);
		longint sb, cb, s1, c1, s2, c2, ar, ai, br, bi;
		rotated_pair_t r;
		begin
			half_angle_trig(beta_q, sb, cb);
			half_angle_trig(alpha_q + gamma_q, s1, c1);
			half_angle_trig(alpha_q - gamma_q, s2, c2);
			ar = round_q30(cb * c1);
			ai = -round_q30(cb * s1);
			br = round_q30(sb * c2);
			bi = -round_q30(sb * s2);
			r.up_re = 18'(round_q30(ar * ur - ai * ui - br * dr + bi * di));
			r.up_im = 18'(round_q30(ar * ui + ai * ur - br * di - bi * dr));
			r.dn_re = 18'(round_q30(ar * dr + ai * di + br * ur + bi * ui));
			r.dn_im = 18'(round_q30(ar * di - ai * dr + br * ui - bi * ur));
			r.eom = eom;
			return r;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q <= '0;
			gamma_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_ALPHA: alpha_q <= pwdata[15:0];
				REG_BETA:  beta_q <= pwdata[15:0];
				REG_GAMMA: gamma_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
		pairs_checked = 0;
		mismatches = 0;
	end

	always @(posedge clk) begin
		rotated_pair_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				rotated_q.push_back(rotate_pair(longint'(up_re), longint'(up_im),
					longint'(down_re), longint'(down_im), last_pair));
			if (out_valid && out_ready) begin
				if (rotated_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected output transaction");
				end else begin
					want = rotated_q.pop_front();
					pairs_checked++;
					if (want.up_re !== new_up_re || want.up_im !== new_up_im ||
							want.dn_re !== new_down_re || want.dn_im !== new_down_im ||
							want.eom !== end_of_matrix) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
								want.up_re, want.up_im, want.dn_re, want.dn_im, want.eom,
								new_up_re, new_up_im, new_down_re, new_down_im,
								end_of_matrix);
					end
				end
			end
			pending <= rotated_q.size();
			fail_count <= mismatches;
		end
	end

endmodule

// ===== test/tb_spinor_pair_euler_rotation_core.sv =====
`timescale 1ns / 1ps
module tb_spinor_pair_euler_rotation_core;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 300;
	localparam logic [3:0] ADDR_ALPHA = 4'h0;
	localparam logic [3:0] ADDR_BETA  = 4'h4;
	localparam logic [3:0] ADDR_GAMMA = 4'h8;
	localparam logic [3:0] ADDR_SPARE = 4'hC;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] up_re = '0, up_im = '0, down_re = '0, down_im = '0;
	logic last_pair = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [17:0] new_up_re, new_up_im, new_down_re, new_down_im;
	logic end_of_matrix;

	int fail_count, pending, pairs_checked;
	int hold_requests = 0;
	bit quiet = 0;
	int idle_cycles = 0;
	int writes_done = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	spinor_pair_euler_rotation_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.up_re(up_re), .up_im(up_im), .down_re(down_re), .down_im(down_im),
		.last_pair(last_pair),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_up_re(new_up_re), .new_up_im(new_up_im), .new_down_re(new_down_re),
		.new_down_im(new_down_im), .end_of_matrix(end_of_matrix)
	);

	spe_rotation_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.up_re(up_re), .up_im(up_im), .down_re(down_re), .down_im(down_im),
		.last_pair(last_pair),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_up_re(new_up_re), .new_up_im(new_up_im), .new_down_re(new_down_re),
		.new_down_im(new_down_im), .end_of_matrix(end_of_matrix),
		.fail_count(fail_count), .pending(pending), .pairs_checked(pairs_checked)
	);

	// receiver: random stalls plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		int holds_seen;
		stall_left = 0;
		hold_left = 0;
		holds_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_seen) begin
				holds_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 6);
				out_ready <= 0;
			end else begin
				out_ready <= 1;
			end
		end
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", pending);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic reg_write(input logic [3:0] addr, input logic [31:0] data);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		writes_done++;
	endtask

	task automatic set_angles(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] g);
		in_valid <= 0;
		while (pending != 0 || u_checker.rotated_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		reg_write(ADDR_ALPHA, {16'($urandom()), a});
		reg_write(ADDR_BETA, {16'($urandom()), b});
		reg_write(ADDR_GAMMA, {16'($urandom()), g});
		reg_write(ADDR_SPARE, $urandom());
	endtask

	task automatic send_pair(input logic [15:0] ur, input logic [15:0] ui,
			input logic [15:0] dr, input logic [15:0] di, input logic lp);
		in_valid <= 1;
		up_re <= ur;
		up_im <= ui;
		down_re <= dr;
		down_im <= di;
		last_pair <= lp;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_pair(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
				(i % 16 == 15) || ($urandom_range(0, 9) == 0));
	endtask

	task automatic send_extremes();
		send_pair(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0);
		send_pair(16'h8000, 16'h8000, 16'h8000, 16'h8000, 0);
		send_pair(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0);
		send_pair(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1);
		send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		send_pair(16'h4000, 16'h0000, 16'h0000, 16'h0000, 1);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// reset angles, then directed extremes under a few rotations
		send_extremes();
		set_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_extremes();
		set_angles(16'h8000, 16'h8000, 16'h8000);
		send_extremes();
		set_angles(16'h4000, 16'h2000, 16'hC000);
		send_extremes();

		for (int ph = 0; ph < 8; ph++) begin
			set_angles(16'($urandom()), 16'($urandom()), 16'($urandom()));
			if (ph == 3) begin
				hold_requests <= hold_requests + 1;
				send_random(LONG_HOLD / 2);
			end
			if (ph == 7) quiet = 1;
			send_random(140);
		end
		in_valid <= 0;

		while (pending != 0 || u_checker.rotated_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("checked %0d rotated pairs over %0d register writes,", pairs_checked,
			writes_done);
		$display("including extreme samples and angles, stalls and a long hold-off");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
design/spe_pkg.sv
design/spe_trig_engine.sv
design/spe_mac_pipe.sv
design/spinor_pair_euler_rotation_core.sv
design/spe_checker.sv
test/spe_rotation_checker.sv
test/tb_spinor_pair_euler_rotation_core.sv
